// ----- rtl/chunk_cache_lru_manager_assert.svh -----
// ----------------------------------------------------------------------------
// chunk cache lru manager assertion macros
// shared concurrent assertion forms on clk_i with rst_ni as disable
// ----------------------------------------------------------------------------
`ifndef CHUNK_CACHE_LRU_MANAGER_ASSERT_SVH
`define CHUNK_CACHE_LRU_MANAGER_ASSERT_SVH

// same-cycle implication
`define CCLM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCLM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cclm_pkg.sv -----
// ----------------------------------------------------------------------------
// cclm_pkg
// constants, beat layouts and types of the chunk cache lru manager
// ----------------------------------------------------------------------------
`default_nettype none

package cclm_pkg;

  localparam int SLOTS           = 64;
  localparam int CHUNK_SIDE_BITS = 7;
  localparam int COORD_BITS      = 20;

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int IDX_W   = $clog2(SLOTS + 1);
  localparam int CHUNK_W = COORD_BITS - CHUNK_SIDE_BITS;
  localparam int TAG_W   = 3 * CHUNK_W;
  localparam int STAMP_W = 64;

  localparam int OP_W        = 2;
  localparam int COORD_W     = 20;
  localparam int VAL_W       = 8;
  localparam int OUT_SLOT_W  = 6;
  localparam int OFFSET_W    = 21;
  localparam int OUT_CHUNK_W = 13;

  localparam int IN_FIELDS_W  = OP_W + 3 * COORD_W + VAL_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = OUT_SLOT_W + OFFSET_W + 3 + VAL_W + 3 * OUT_CHUNK_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic {
    KIND_ACCESS    = 1'b0,
    KIND_WRITEBACK = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CUR,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_WB,
    ST_ACC,
    ST_FLUSH,
    ST_FEMIT
  } state_e;

  typedef struct packed {
    logic [IN_TDATA_W-IN_FIELDS_W-1:0] pad;
    logic [VAL_W-1:0]                  write_value;
    logic [COORD_W-1:0]                coord_z;
    logic [COORD_W-1:0]                coord_y;
    logic [COORD_W-1:0]                coord_x;
    logic [OP_W-1:0]                   op;
  } in_data_t;

  typedef struct packed {
    logic [OUT_TDATA_W-OUT_FIELDS_W-1:0] pad;
    logic [OUT_CHUNK_W-1:0]              chunk_z;
    logic [OUT_CHUNK_W-1:0]              chunk_y;
    logic [OUT_CHUNK_W-1:0]              chunk_x;
    logic [VAL_W-1:0]                    store_value;
    logic                                store_enable;
    logic                                fill_needed;
    logic                                hit;
    logic [OFFSET_W-1:0]                 offset;
    logic [OUT_SLOT_W-1:0]               slot;
  } out_data_t;

  typedef struct packed {
    logic              step;
    logic [SLOT_W-1:0] idx;
    logic              slot_valid;
  } scan_step_t;

  typedef struct packed {
    logic              match;
    logic [SLOT_W-1:0] match_idx;
    logic              free;
    logic [SLOT_W-1:0] free_idx;
    logic [SLOT_W-1:0] min_idx;
    logic [TAG_W-1:0]  min_tag;
  } scan_res_t;

endpackage

`default_nettype wire

// ----- rtl/cclm_ram.sv -----
// ----------------------------------------------------------------------------
// cclm_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module cclm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/cclm_scan_unit.sv -----
// ----------------------------------------------------------------------------
// cclm_scan_unit
// shared tag and stamp compare, one slot per beat: first match, first free
// slot and oldest stamp
// ----------------------------------------------------------------------------
`default_nettype none

module cclm_scan_unit import cclm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire scan_step_t         ctl_i,
  input  wire logic [TAG_W-1:0]   key_i,
  input  wire logic [TAG_W-1:0]   tag_i,
  input  wire logic [STAMP_W-1:0] stamp_i,
  output scan_res_t               res_o
);

  logic               match_q, match_d;
  logic [SLOT_W-1:0]  match_idx_q, match_idx_d;
  logic               free_q, free_d;
  logic [SLOT_W-1:0]  free_idx_q, free_idx_d;
  logic [SLOT_W-1:0]  min_idx_q, min_idx_d;
  logic [STAMP_W-1:0] min_stamp_q, min_stamp_d;
  logic [TAG_W-1:0]   min_tag_q, min_tag_d;
  logic               first, hit_now, older;

  always_comb begin
    first       = (ctl_i.idx == '0);
    hit_now     = ctl_i.slot_valid && (tag_i == key_i);
    older       = (stamp_i < min_stamp_q);
    match_d     = match_q;
    match_idx_d = match_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    min_idx_d   = min_idx_q;
    min_stamp_d = min_stamp_q;
    min_tag_d   = min_tag_q;
    if (ctl_i.step) begin
      if (first) begin
        match_d     = hit_now;
        match_idx_d = ctl_i.idx;
        free_d      = !ctl_i.slot_valid;
        free_idx_d  = ctl_i.idx;
        min_idx_d   = ctl_i.idx;
        min_stamp_d = stamp_i;
        min_tag_d   = tag_i;
      end else begin
        if (!match_q && hit_now) begin
          match_d     = 1'b1;
          match_idx_d = ctl_i.idx;
        end
        if (!free_q && !ctl_i.slot_valid) begin
          free_d     = 1'b1;
          free_idx_d = ctl_i.idx;
        end
        if (older) begin
          min_idx_d   = ctl_i.idx;
          min_stamp_d = stamp_i;
          min_tag_d   = tag_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      match_q <= match_d;
      free_q  <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
    min_idx_q   <= min_idx_d;
    min_stamp_q <= min_stamp_d;
    min_tag_q   <= min_tag_d;
  end

  assign res_o.match     = match_q;
  assign res_o.match_idx = match_idx_q;
  assign res_o.free      = free_q;
  assign res_o.free_idx  = free_idx_q;
  assign res_o.min_idx   = min_idx_q;
  assign res_o.min_tag   = min_tag_q;

endmodule

`default_nettype wire

// ----- rtl/chunk_cache_lru_manager.sv -----
// ----------------------------------------------------------------------------
// chunk_cache_lru_manager
// tag and lru replacement manager for a fully associative voxel chunk cache
// ----------------------------------------------------------------------------
// channel   dir  tdata                                        tuser  tlast
// s_axis    in   op, coord_x, coord_y, coord_z, write_value   -      -
// m_axis    out  slot, offset, hit, fill_needed, store_enable,
//                store_value, chunk_x, chunk_y, chunk_z       kind   last
//
// hit on the current slot: ST_CUR compares its tag, then ST_ACC emits the beat
// other read or write: ST_CUR (skipped before any slot is current), ST_SCAN
//   over every slot, ST_DRAIN, ST_DECIDE, ST_WB with a dirty victim, then
//   ST_ACC; the tag and stamp scan through the slot rams is serial
// flush: one slot test per cycle, a dirty slot detours through ST_FEMIT
// no clearing pass after reset; valid and dirty bits reset in flip-flops
// a stalled result beat holds the sequencer in its emitting state
// ----------------------------------------------------------------------------
`default_nettype none

module chunk_cache_lru_manager import cclm_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // op, coord_x, coord_y, coord_z, write_value
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // slot, offset, hit, fill_needed, store_enable, store_value,
  // chunk_x, chunk_y, chunk_z
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  // kind
  output logic                        m_axis_tuser_o,
  output logic                        m_axis_tlast_o
);

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               rd_vld_q;
  logic [SLOT_W-1:0]  rd_idx_q;
  op_e                op_q, op_d;
  logic [TAG_W-1:0]   key_q, key_d;
  logic [OFFSET_W-1:0] off_q, off_d;
  logic [VAL_W-1:0]   wv_q, wv_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic               hit_q, hit_d;
  logic [SLOT_W-1:0]  cur_slot_q, cur_slot_d;
  logic               cur_vld_q, cur_vld_d;
  logic [STAMP_W-1:0] counter_q, counter_d;
  logic [SLOTS-1:0]   valid_q, valid_d;
  logic [SLOTS-1:0]   dirty_q, dirty_d;
  logic               out_vld_q, out_vld_d;
  out_data_t          out_data_q, out_data_d;
  kind_e              out_kind_q, out_kind_d;
  logic               out_last_q, out_last_d;

  in_data_t           in_beat;
  logic               accept, out_free, flush_last;
  logic [SLOTS-1:0]   above_m;
  logic [SLOT_W-1:0]  fidx;
  logic [TAG_W-1:0]   wb_tag;
  logic               wb_load;

  logic               tag_we, stamp_we;
  logic [SLOT_W-1:0]  raddr, waddr;
  logic [TAG_W-1:0]   tag_rdata;
  logic [STAMP_W-1:0] stamp_rdata;
  scan_step_t         scan_ctl;
  scan_res_t          scan_res;

  assign in_beat         = in_data_t'(s_axis_tdata_i);
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign fidx            = idx_q[SLOT_W-1:0];
  assign above_m         = ({SLOTS{1'b1}} << fidx) << 1;
  assign flush_last      = ~|(valid_q & dirty_q & above_m);

  always_comb begin
    case (state_q)
      ST_SCAN, ST_FLUSH, ST_FEMIT: raddr = fidx;
      default:                     raddr = cur_slot_q;
    endcase
  end

  cclm_ram #(.Width(TAG_W), .Depth(SLOTS)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (waddr),
    .wdata_i (key_q),
    .raddr_i (raddr),
    .rdata_o (tag_rdata)
  );

  cclm_ram #(.Width(STAMP_W), .Depth(SLOTS)) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (stamp_we),
    .waddr_i (waddr),
    .wdata_i (counter_q),
    .raddr_i (raddr),
    .rdata_o (stamp_rdata)
  );

  assign scan_ctl.step       = rd_vld_q;
  assign scan_ctl.idx        = rd_idx_q;
  assign scan_ctl.slot_valid = valid_q[rd_idx_q];

  cclm_scan_unit u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (scan_ctl),
    .key_i   (key_q),
    .tag_i   (tag_rdata),
    .stamp_i (stamp_rdata),
    .res_o   (scan_res)
  );

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    op_d       = op_q;
    key_d      = key_q;
    off_d      = off_q;
    wv_d       = wv_q;
    slot_d     = slot_q;
    hit_d      = hit_q;
    cur_slot_d = cur_slot_q;
    cur_vld_d  = cur_vld_q;
    counter_d  = counter_q;
    valid_d    = valid_q;
    dirty_d    = dirty_q;
    out_data_d = out_data_q;
    out_kind_d = out_kind_q;
    out_last_d = out_last_q;
    out_vld_d  = m_axis_tready_i ? 1'b0 : out_vld_q;
    tag_we     = 1'b0;
    stamp_we   = 1'b0;
    waddr      = slot_q;
    wb_load    = 1'b0;
    wb_tag     = tag_rdata;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d  = op_e'(in_beat.op);
          key_d = {in_beat.coord_x[COORD_BITS-1:CHUNK_SIDE_BITS],
                   in_beat.coord_y[COORD_BITS-1:CHUNK_SIDE_BITS],
                   in_beat.coord_z[COORD_BITS-1:CHUNK_SIDE_BITS]};
          off_d = OFFSET_W'({in_beat.coord_x[CHUNK_SIDE_BITS-1:0],
                             in_beat.coord_y[CHUNK_SIDE_BITS-1:0],
                             in_beat.coord_z[CHUNK_SIDE_BITS-1:0]});
          wv_d  = in_beat.write_value;
          idx_d = '0;
          case (op_e'(in_beat.op))
            OP_FLUSH:          state_d = ST_FLUSH;
            OP_READ, OP_WRITE: state_d = cur_vld_q ? ST_CUR : ST_SCAN;
            default:           state_d = ST_IDLE;
          endcase
        end
      end
      ST_CUR: begin
        if (tag_rdata == key_q) begin
          slot_d  = cur_slot_q;
          hit_d   = 1'b1;
          state_d = ST_ACC;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == IDX_W'(SLOTS - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        stamp_we   = 1'b1;
        counter_d  = counter_q + 1'b1;
        cur_vld_d  = 1'b1;
        state_d    = ST_ACC;
        if (scan_res.match) begin
          slot_d = scan_res.match_idx;
          hit_d  = 1'b1;
        end else begin
          slot_d = scan_res.free ? scan_res.free_idx : scan_res.min_idx;
          hit_d  = 1'b0;
          tag_we = 1'b1;
          valid_d[slot_d] = 1'b1;
          dirty_d[slot_d] = 1'b0;
          if (!scan_res.free && dirty_q[scan_res.min_idx]) begin
            state_d = ST_WB;
          end
        end
        waddr      = slot_d;
        cur_slot_d = slot_d;
      end
      ST_WB: begin
        if (out_free) begin
          wb_load    = 1'b1;
          wb_tag     = scan_res.min_tag;
          out_last_d = 1'b0;
          state_d    = ST_ACC;
        end
      end
      ST_ACC: begin
        if (out_free) begin
          out_vld_d               = 1'b1;
          out_kind_d              = KIND_ACCESS;
          out_last_d              = 1'b1;
          out_data_d              = '0;
          out_data_d.slot         = OUT_SLOT_W'(slot_q);
          out_data_d.offset       = off_q;
          out_data_d.hit          = hit_q;
          out_data_d.fill_needed  = !hit_q;
          if (op_q == OP_WRITE) begin
            out_data_d.store_enable = 1'b1;
            out_data_d.store_value  = wv_q;
            dirty_d[slot_q]         = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (idx_q == IDX_W'(SLOTS)) begin
          state_d = ST_IDLE;
        end else if (valid_q[fidx] && dirty_q[fidx]) begin
          state_d = ST_FEMIT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_FEMIT: begin
        if (out_free) begin
          wb_load       = 1'b1;
          slot_d        = fidx;
          out_last_d    = flush_last;
          dirty_d[fidx] = 1'b0;
          idx_d         = idx_q + 1'b1;
          state_d       = ST_FLUSH;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (wb_load) begin
      out_vld_d          = 1'b1;
      out_kind_d         = KIND_WRITEBACK;
      out_data_d         = '0;
      out_data_d.slot    = OUT_SLOT_W'(slot_d);
      out_data_d.chunk_x = OUT_CHUNK_W'(wb_tag[TAG_W-1 -: CHUNK_W]);
      out_data_d.chunk_y = OUT_CHUNK_W'(wb_tag[2*CHUNK_W-1 -: CHUNK_W]);
      out_data_d.chunk_z = OUT_CHUNK_W'(wb_tag[CHUNK_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      rd_vld_q   <= 1'b0;
      cur_slot_q <= '0;
      cur_vld_q  <= 1'b0;
      counter_q  <= STAMP_W'(1);
      valid_q    <= '0;
      dirty_q    <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      rd_vld_q   <= (state_q == ST_SCAN);
      cur_slot_q <= cur_slot_d;
      cur_vld_q  <= cur_vld_d;
      counter_q  <= counter_d;
      valid_q    <= valid_d;
      dirty_q    <= dirty_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= fidx;
    op_q       <= op_d;
    key_q      <= key_d;
    off_q      <= off_d;
    wv_q       <= wv_d;
    slot_q     <= slot_d;
    hit_q      <= hit_d;
    out_data_q <= out_data_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/cclm_checker.sv -----
// ----------------------------------------------------------------------------
// cclm_checker
// port level checks of the chunk cache lru manager, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "chunk_cache_lru_manager_assert.svh"

module cclm_checker import cclm_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid_i,
  input wire logic                   s_axis_tready_o,
  input wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input wire logic                   m_axis_tvalid_o,
  input wire logic                   m_axis_tready_i,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input wire logic                   m_axis_tuser_o,
  input wire logic                   m_axis_tlast_o
);

  in_data_t  ib;
  out_data_t ob;
  logic      acc_beat, wb_beat;

  assign ib       = in_data_t'(s_axis_tdata_i);
  assign ob       = out_data_t'(m_axis_tdata_o);
  assign acc_beat = m_axis_tvalid_o && (m_axis_tuser_o == KIND_ACCESS);
  assign wb_beat  = m_axis_tvalid_o && (m_axis_tuser_o == KIND_WRITEBACK);

  `CCLM_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o),
    "stalled result beat changed")
  `CCLM_ASSERT_NEXT(a_busy_after_accept,
    s_axis_tvalid_i && s_axis_tready_o && (ib.op != OP_NONE), !s_axis_tready_o,
    "ready while an accepted request is in work")
  `CCLM_ASSERT_NOW(a_access_last, acc_beat, m_axis_tlast_o,
    "access beat without last")
  `CCLM_ASSERT_NOW(a_fill_vs_hit, acc_beat, ob.fill_needed != ob.hit,
    "fill_needed and hit disagree")
  `CCLM_ASSERT_NOW(a_wb_fields, wb_beat,
    ob.offset == '0 && !ob.hit && !ob.fill_needed && !ob.store_enable &&
    ob.store_value == '0, "writeback beat carries access fields")

endmodule

bind chunk_cache_lru_manager cclm_checker u_cclm_checker (.*);

`default_nettype wire

// ----- dv/chunk_cache_lru_manager_test.sv -----
// ----------------------------------------------------------------------------
// chunk_cache_lru_manager_test
// self-checking bench for the chunk cache lru manager: a scoreboard class
// mirrors slot tags, dirty marks and use stamps, predicts every result beat
// of each accepted request and checks the output stream in order, under
// directed corner requests and pooled random traffic with idle phases
// ----------------------------------------------------------------------------
`default_nettype none

module chunk_cache_lru_manager_test import cclm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 360;
  localparam int PHASES         = 4;
  localparam int POOL_SIZE      = 96;

  typedef struct packed {
    kind_e     kind;
    logic      last;
    out_data_t data;
  } beat_t;

  class chunk_tag_scoreboard;
    bit                 slot_used[SLOTS];
    bit                 slot_dirty[SLOTS];
    logic [CHUNK_W-1:0] tag_x[SLOTS];
    logic [CHUNK_W-1:0] tag_y[SLOTS];
    logic [CHUNK_W-1:0] tag_z[SLOTS];
    bit [STAMP_W-1:0]   slot_stamp[SLOTS];
    bit [STAMP_W-1:0]   use_count = 1;
    int unsigned        cur_slot = 0;
    bit                 cur_used = 0;
    beat_t              pending_beats[$];
    int                 mismatches = 0;
    int                 checked = 0;
    int                 requests = 0;
    int                 hits = 0;
    int                 misses = 0;
    int                 writebacks = 0;

    function int pending();
      return pending_beats.size();
    endfunction

    function bit tag_hit(int unsigned s, logic [CHUNK_W-1:0] cx, logic [CHUNK_W-1:0] cy,
                         logic [CHUNK_W-1:0] cz);
      return slot_used[s] && tag_x[s] == cx && tag_y[s] == cy && tag_z[s] == cz;
    endfunction

    function beat_t writeback_beat(int unsigned s);
      beat_t b;
      b = '0;
      b.kind = KIND_WRITEBACK;
      b.data.slot = OUT_SLOT_W'(s);
      b.data.chunk_x = OUT_CHUNK_W'(tag_x[s]);
      b.data.chunk_y = OUT_CHUNK_W'(tag_y[s]);
      b.data.chunk_z = OUT_CHUNK_W'(tag_z[s]);
      writebacks++;
      return b;
    endfunction

    function void note_request(in_data_t req);
      op_e                op;
      beat_t              b;
      logic [CHUNK_W-1:0] cx, cy, cz;
      int unsigned        slot;
      bit                 found, hit;
      bit [STAMP_W-1:0]   best;
      int                 n;
      op = op_e'(req.op);
      requests++;
      if (op == OP_NONE) return;
      if (op == OP_FLUSH) begin
        n = 0;
        for (int s = 0; s < SLOTS; s++) begin
          if (slot_used[s] && slot_dirty[s]) begin
            pending_beats.push_back(writeback_beat(s));
            slot_dirty[s] = 0;
            n++;
          end
        end
        if (n > 0) begin
          b = pending_beats.pop_back();
          b.last = 1'b1;
          pending_beats.push_back(b);
        end
        return;
      end
      cx = req.coord_x[COORD_W-1:CHUNK_SIDE_BITS];
      cy = req.coord_y[COORD_W-1:CHUNK_SIDE_BITS];
      cz = req.coord_z[COORD_W-1:CHUNK_SIDE_BITS];
      slot = 0;
      hit = 0;
      found = 0;
      if (cur_used && tag_hit(cur_slot, cx, cy, cz)) begin
        slot = cur_slot;
        hit = 1;
      end else begin
        for (int s = 0; s < SLOTS; s++) begin
          if (!found && tag_hit(s, cx, cy, cz)) begin
            slot = s;
            found = 1;
          end
        end
        if (found) begin
          hit = 1;
          slot_stamp[slot] = use_count;
          use_count++;
        end else begin
          for (int s = 0; s < SLOTS; s++) begin
            if (!found && !slot_used[s]) begin
              slot = s;
              found = 1;
            end
          end
          if (!found) begin
            best = slot_stamp[0];
            slot = 0;
            for (int s = 1; s < SLOTS; s++) begin
              if (slot_stamp[s] < best) begin
                best = slot_stamp[s];
                slot = s;
              end
            end
            if (slot_dirty[slot]) pending_beats.push_back(writeback_beat(slot));
          end
          slot_used[slot] = 1;
          tag_x[slot] = cx;
          tag_y[slot] = cy;
          tag_z[slot] = cz;
          slot_stamp[slot] = use_count;
          use_count++;
          slot_dirty[slot] = 0;
        end
        cur_slot = slot;
        cur_used = 1;
      end
      if (hit) hits++; else misses++;
      b = '0;
      b.kind = KIND_ACCESS;
      b.last = 1'b1;
      b.data.slot = OUT_SLOT_W'(slot);
      b.data.offset = {req.coord_x[CHUNK_SIDE_BITS-1:0], req.coord_y[CHUNK_SIDE_BITS-1:0],
                       req.coord_z[CHUNK_SIDE_BITS-1:0]};
      b.data.hit = hit;
      b.data.fill_needed = !hit;
      if (op == OP_WRITE) begin
        slot_dirty[slot] = 1;
        b.data.store_enable = 1'b1;
        b.data.store_value = req.write_value;
      end
      pending_beats.push_back(b);
    endfunction

    function string beat_str(logic kind, logic last, out_data_t d);
      return $sformatf("kind %b slot %0d off %h hit %b fill %b se %b sv %h chunk %h/%h/%h last %b",
                       kind, d.slot, d.offset, d.hit, d.fill_needed, d.store_enable,
                       d.store_value, d.chunk_x, d.chunk_y, d.chunk_z, last);
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t mismatch: %s", $realtime, what);
    endfunction

    function void check_beat(out_data_t got, logic user, logic last);
      beat_t want;
      bit    bad;
      checked++;
      if (pending_beats.size() == 0) begin
        report({"unexpected beat ", beat_str(user, last, got)});
        return;
      end
      want = pending_beats.pop_front();
      bad = (want.kind !== user) || (want.last !== last) ||
            (want.data.slot !== got.slot) || (want.data.offset !== got.offset) ||
            (want.data.hit !== got.hit) || (want.data.fill_needed !== got.fill_needed) ||
            (want.data.store_enable !== got.store_enable) ||
            (want.data.store_value !== got.store_value) ||
            (want.data.chunk_x !== got.chunk_x) || (want.data.chunk_y !== got.chunk_y) ||
            (want.data.chunk_z !== got.chunk_z);
      if (bad) begin
        report({"expected ", beat_str(want.kind, want.last, want.data)});
        if (mismatches <= 10) $display("  actual   %s", beat_str(user, last, got));
      end
    endfunction

    function void report_leftover();
      if (pending_beats.size() != 0)
        report($sformatf("%0d expected beats never arrived", pending_beats.size()));
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      s_tvalid = 1'b0;
  in_data_t  s_tdata = '0;
  logic      s_tready;
  logic      m_tvalid;
  logic      m_tready = 1'b0;
  out_data_t m_data;
  logic      m_user;
  logic      m_last;

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  chunk_tag_scoreboard sb = new();

  logic [CHUNK_W-1:0] pool_x[POOL_SIZE];
  logic [CHUNK_W-1:0] pool_y[POOL_SIZE];
  logic [CHUNK_W-1:0] pool_z[POOL_SIZE];

  chunk_cache_lru_manager dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) sb.check_beat(m_data, m_user, m_last);
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  task automatic send_item(in_data_t d);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sb.note_request(d);
  endtask

  task automatic send_req(op_e op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                          logic [COORD_W-1:0] z, logic [VAL_W-1:0] v);
    in_data_t d;
    d = '0;
    d.op = op;
    d.coord_x = x;
    d.coord_y = y;
    d.coord_z = z;
    d.write_value = v;
    send_item(d);
  endtask

  // hold off the sender until every predicted beat is out
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int                 sent;
    int                 r;
    int                 k;
    op_e                op;
    logic [CHUNK_W-1:0] cx, cy, cz;
    logic [CHUNK_W-1:0] last_x, last_y, last_z;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    send_req(OP_FLUSH, '0, '0, '0, '0);
    send_req(OP_NONE, 20'h12345, 20'h6789a, 20'hbcdef, 8'h3c);
    send_req(OP_READ, '0, '0, '0, '0);
    send_req(OP_WRITE, '0, '0, 20'd1, 8'hff);
    send_req(OP_READ, '1, '1, '1, 8'hff);
    send_req(OP_WRITE, '1, '1, '1, 8'h00);
    send_req(OP_WRITE, '0, '0, '0, 8'ha5);
    send_req(OP_READ, 20'h7f, 20'h7f, 20'h7f, '0);
    send_req(OP_NONE, '1, '1, '1, '1);
    send_req(OP_FLUSH, '1, '1, '1, '1);
    send_req(OP_FLUSH, '0, '0, '0, '0);
    send_req(OP_WRITE, 20'haaaaa, 20'h55555, 20'haaaaa, 8'h5a);
    send_req(OP_READ, 20'h55555, 20'haaaaa, 20'h55555, 8'ha5);
    send_req(OP_READ, 20'haaaaa, 20'h55555, 20'haaaaa, '0);
    send_req(OP_WRITE, 20'h00080, 20'h00000, 20'hfff80, 8'h81);
    send_req(OP_FLUSH, '0, '0, '0, '0);

    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_x[i] = CHUNK_W'($urandom);
      pool_y[i] = CHUNK_W'($urandom);
      pool_z[i] = CHUNK_W'($urandom);
    end
    pool_x[0] = '0; pool_y[0] = '0; pool_z[0] = '0;
    pool_x[1] = '1; pool_y[1] = '1; pool_z[1] = '1;
    last_x = '0; last_y = '0; last_z = '0;

    sent = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin sender_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      while (sent < (phase + 1) * RANDOM_ITEMS / PHASES) begin
        r = $urandom_range(99);
        if (r < 6) op = OP_FLUSH;
        else if (r < 10) op = OP_NONE;
        else if (r < 55) op = OP_READ;
        else op = OP_WRITE;
        r = $urandom_range(99);
        if (r < 30) begin
          cx = last_x; cy = last_y; cz = last_z;
        end else if (r < 85) begin
          k = $urandom_range(POOL_SIZE - 1);
          cx = pool_x[k]; cy = pool_y[k]; cz = pool_z[k];
        end else begin
          cx = CHUNK_W'($urandom); cy = CHUNK_W'($urandom); cz = CHUNK_W'($urandom);
        end
        if (op == OP_READ || op == OP_WRITE) begin
          last_x = cx; last_y = cy; last_z = cz;
        end
        send_req(op, {cx, 7'($urandom)}, {cy, 7'($urandom)}, {cz, 7'($urandom)},
                 VAL_W'($urandom));
        sent++;
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2 * SLOTS + 16) @(posedge clk_i);
    sb.report_leftover();
    $display("covered %0d requests: %0d hits, %0d misses, %0d writebacks, %0d beats checked",
             sb.requests, sb.hits, sb.misses, sb.writebacks, sb.checked);
    $display("idle phases: none, sender 66%%, receiver 66%%, both 27%%; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/cclm_pkg.sv
rtl/cclm_ram.sv
rtl/cclm_scan_unit.sv
rtl/chunk_cache_lru_manager.sv
rtl/cclm_checker.sv
dv/chunk_cache_lru_manager_test.sv
